// ----- hdl/pcd_pkg.sv -----
// Shared types, codes and constants for the PNG chunk deframer.
`default_nettype none
package pcd_pkg;

   localparam logic [2:0] ROLE_SIG     = 3'd0;
   localparam logic [2:0] ROLE_LEN     = 3'd1;
   localparam logic [2:0] ROLE_TYPE    = 3'd2;
   localparam logic [2:0] ROLE_DATA    = 3'd3;
   localparam logic [2:0] ROLE_CRC     = 3'd4;
   localparam logic [2:0] ROLE_IGNORED = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIG  = 2'd1;
   localparam logic [1:0] STATUS_BAD_END  = 2'd2;

   localparam logic [31:0] IEND_TYPE = 32'h4945_4e44;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  data_byte;
      logic [31:0] chunk_length;
      logic [31:0] chunk_type;
      logic [31:0] chunk_crc;
      logic        chunk_done;
      logic        stream_done;
      logic [1:0]  status;
   } result_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h89;
         3'd1:    val = 8'h50;
         3'd2:    val = 8'h4e;
         3'd3:    val = 8'h47;
         3'd4:    val = 8'h0d;
         3'd5:    val = 8'h0a;
         3'd6:    val = 8'h1a;
         3'd7:    val = 8'h0a;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/pcd_ifs.sv -----
// Request and response channel interfaces of the PNG chunk deframer.
`default_nettype none
interface pcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;

   modport source (output valid, output byte_value, input ready);
   modport sink (input valid, input byte_value, output ready);
endinterface

interface pcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_role;
   logic [7:0]  data_byte;
   logic [31:0] chunk_length;
   logic [31:0] chunk_type;
   logic [31:0] chunk_crc;
   logic        chunk_done;
   logic        stream_done;
   logic [1:0]  status;

   modport source (output valid, output byte_role, output data_byte, output chunk_length,
                   output chunk_type, output chunk_crc, output chunk_done,
                   output stream_done, output status, input ready);
   modport sink (input valid, input byte_role, input data_byte, input chunk_length,
                 input chunk_type, input chunk_crc, input chunk_done,
                 input stream_done, input status, output ready);
endinterface
`default_nettype wire

// ----- hdl/pcd_parser.sv -----
// Chunk framing state machine: labels one byte per step and assembles fields.
`default_nettype none
module pcd_parser import pcd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] byte_value,
   output result_type      result
);

   typedef enum logic [2:0] {
      PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC, PH_HALT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] count_inc;
   logic [31:0] len_ff, len_in;
   logic [31:0] typ_ff, typ_in;
   logic [31:0] crc_ff, crc_in;
   logic        end_ff, end_in;
   logic [1:0]  err_ff, err_in;
   logic [2:0]  role;
   logic        cdone;
   logic        new_chunk;

   assign count_inc = count_ff + 32'd1;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      typ_in   = typ_ff;
      crc_in   = crc_ff;
      end_in   = end_ff;
      err_in   = err_ff;
      role     = ROLE_IGNORED;
      cdone    = 1'b0;
      case (phase_ff)
         PH_SIG: begin
            role = ROLE_SIG;
            if (byte_value != sig_byte(count_ff[2:0])) begin
               err_in   = STATUS_BAD_SIG;
               phase_in = PH_HALT;
               count_in = '0;
            end else if (count_ff[2:0] == 3'd7) begin
               phase_in = PH_LEN;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_LEN: begin
            role   = ROLE_LEN;
            len_in = {len_ff[23:0], byte_value};
            if (count_ff[1:0] == 2'd3) begin
               if (len_in == '0) begin
                  end_in = 1'b1;
               end
               phase_in = PH_TYPE;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_TYPE: begin
            role   = ROLE_TYPE;
            typ_in = {typ_ff[23:0], byte_value};
            if (count_ff[1:0] == 2'd3) begin
               count_in = '0;
               if (end_ff && typ_in != IEND_TYPE) begin
                  err_in   = STATUS_BAD_END;
                  phase_in = PH_HALT;
               end else if (len_ff == '0) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               count_in = count_inc;
            end
         end
         PH_DATA: begin
            role = ROLE_DATA;
            if (count_inc == len_ff) begin
               phase_in = PH_CRC;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_CRC: begin
            role   = ROLE_CRC;
            crc_in = {crc_ff[23:0], byte_value};
            if (count_ff[1:0] == 2'd3) begin
               cdone    = 1'b1;
               count_in = '0;
               phase_in = end_ff ? PH_HALT : PH_LEN;
            end else begin
               count_in = count_inc;
            end
         end
         default: begin
            role = ROLE_IGNORED;
         end
      endcase
   end

   assign new_chunk = cdone && !end_ff;

   always_comb begin
      result.byte_role    = role;
      result.data_byte    = byte_value;
      result.chunk_length = len_in;
      result.chunk_type   = typ_in;
      result.chunk_crc    = crc_in;
      result.chunk_done   = cdone;
      result.stream_done  = (phase_in == PH_HALT) && (err_in == STATUS_OK) && end_in;
      result.status       = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;
         count_ff <= '0;
         len_ff   <= '0;
         typ_ff   <= '0;
         crc_ff   <= '0;
         end_ff   <= 1'b0;
         err_ff   <= STATUS_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= new_chunk ? '0 : len_in;
         typ_ff   <= new_chunk ? '0 : typ_in;
         crc_ff   <= new_chunk ? '0 : crc_in;
         end_ff   <= end_in;
         err_ff   <= err_in;
      end
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff != STATUS_OK |=> err_ff == $past(err_ff))
      else $error("error code changed after being raised");

   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      end_ff |=> end_ff)
      else $error("end marker cleared");

   a_done_on_crc: assert property (@(posedge clock) disable iff (reset)
      step && cdone |-> phase_ff == PH_CRC && count_ff[1:0] == 2'd3)
      else $error("chunk done outside last CRC byte");

   a_halt_coded: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> end_ff || err_ff != STATUS_OK)
      else $error("halted without end or error");

endmodule
`default_nettype wire

// ----- hdl/png_chunk_deframer.sv -----
// PNG chunk deframer top level: request register, parser and response register.
// Usage:
//   req_chan carries one file byte per request (byte_value); rsp_chan returns one
//   response per byte with its role, the pass-through byte, the length, type and CRC
//   assembled so far, chunk_done, stream_done and status.
//   Requests are taken at the edge where valid and ready are both high.
// Path: a byte accepted into the request register goes through the parser step
//   into the response register, from which it is presented on rsp_chan.
// Throughput: one byte per clock cycle, sustained while rsp_chan.ready stays high,
//   set by the combinational parser step between the two registers.
// Reset: synchronous, active high; the parser returns to the signature check,
//   all fields clear, and both registers empty.
// Stall: while rsp_chan.ready is low the response holds; one more byte is still
//   taken into the request register, after which req_chan.ready drops until the
//   response is taken. No byte is lost or repeated.
// After a bad signature or a zero-length chunk that is not IEND, status holds
//   the error and every later byte is reported as ignored.
`default_nettype none
module png_chunk_deframer import pcd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   pcd_req_if.sink   req_chan,
   pcd_rsp_if.source rsp_chan
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type parse_result;
   logic       advance;
   logic       step;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign step           = in_valid_ff && advance;

   pcd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_value (in_byte_ff),
      .result     (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.byte_value;
      end
      if (step) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.byte_role    = out_ff.byte_role;
   assign rsp_chan.data_byte    = out_ff.data_byte;
   assign rsp_chan.chunk_length = out_ff.chunk_length;
   assign rsp_chan.chunk_type   = out_ff.chunk_type;
   assign rsp_chan.chunk_crc    = out_ff.chunk_crc;
   assign rsp_chan.chunk_done   = out_ff.chunk_done;
   assign rsp_chan.stream_done  = out_ff.stream_done;
   assign rsp_chan.status       = out_ff.status;

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending request dropped while stalled");

   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.stream_done |-> out_ff.status == STATUS_OK)
      else $error("stream done together with an error");

endmodule
`default_nettype wire

// ----- verif/tb_png_chunk_deframer.sv -----
// Self-checking testbench for png_chunk_deframer: byte stimulus, prediction, response check.
`default_nettype none
module tb_png_chunk_deframer;
   import pcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STREAM_BYTES = 1800;
   localparam int unsigned NOISE_BYTES  = 20;
   localparam int unsigned HOLD_AT      = 400;
   localparam int unsigned HOLD_CYCLES  = 120;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef enum logic [2:0] {
      P_SIG, P_LEN, P_TYPE, P_DATA, P_CRC, P_HALT
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] b;
      logic       known;
      result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   pcd_req_if req_chan ();
   pcd_rsp_if rsp_chan ();

   png_chunk_deframer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // signature, then a 2-byte chunk typed IEND (ordinary chunk), extremes in data and crc
   stim_row_type directed_rows [22] = '{
      '{8'h89, 1'b1, '{ROLE_SIG, 8'h89, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h50, 1'b1, '{ROLE_SIG, 8'h50, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h4e, 1'b1, '{ROLE_SIG, 8'h4e, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h47, 1'b1, '{ROLE_SIG, 8'h47, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h0d, 1'b1, '{ROLE_SIG, 8'h0d, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h0a, 1'b1, '{ROLE_SIG, 8'h0a, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h1a, 1'b1, '{ROLE_SIG, 8'h1a, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h0a, 1'b1, '{ROLE_SIG, 8'h0a, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, STATUS_OK}},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h49, 1'b0, '0},
      '{8'h45, 1'b0, '0},
      '{8'h4e, 1'b0, '0},
      '{8'h44, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'hff, 1'b0, '0}
   };

   const logic [7:0] png_magic [8] = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a};

   stim_row_type byte_plan [$];
   result_type   pending_rsp [$];
   int unsigned  mismatch_count = 0;
   int unsigned  rsp_seen = 0;

   // parser mirror
   parse_phase_type ph;
   logic [31:0]     pos;
   logic [31:0]     len_acc;
   logic [31:0]     type_acc;
   logic [31:0]     crc_acc;
   logic            end_flag;
   logic [1:0]      err;

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type r;
      logic       cdone;
      r = '0;
      cdone = 1'b0;
      r.byte_role = ROLE_IGNORED;
      case (ph)
         P_SIG: begin
            r.byte_role = ROLE_SIG;
            if (b != png_magic[pos[2:0]]) begin
               err = STATUS_BAD_SIG;
               ph = P_HALT;
               pos = 0;
            end else if (pos >= 7) begin
               ph = P_LEN;
               pos = 0;
            end else begin
               pos++;
            end
         end
         P_LEN: begin
            r.byte_role = ROLE_LEN;
            len_acc = {len_acc[23:0], b};
            if (pos >= 3) begin
               if (len_acc == 0) end_flag = 1'b1;
               ph = P_TYPE;
               pos = 0;
            end else begin
               pos++;
            end
         end
         P_TYPE: begin
            r.byte_role = ROLE_TYPE;
            type_acc = {type_acc[23:0], b};
            if (pos >= 3) begin
               pos = 0;
               if (end_flag && type_acc != IEND_TYPE) begin
                  err = STATUS_BAD_END;
                  ph = P_HALT;
               end else if (len_acc == 0) begin
                  ph = P_CRC;
               end else begin
                  ph = P_DATA;
               end
            end else begin
               pos++;
            end
         end
         P_DATA: begin
            r.byte_role = ROLE_DATA;
            pos++;
            if (pos >= len_acc) begin
               ph = P_CRC;
               pos = 0;
            end
         end
         P_CRC: begin
            r.byte_role = ROLE_CRC;
            crc_acc = {crc_acc[23:0], b};
            if (pos >= 3) begin
               cdone = 1'b1;
               pos = 0;
               ph = end_flag ? P_HALT : P_LEN;
            end else begin
               pos++;
            end
         end
         default: r.byte_role = ROLE_IGNORED;
      endcase
      r.data_byte    = b;
      r.chunk_length = len_acc;
      r.chunk_type   = type_acc;
      r.chunk_crc    = crc_acc;
      r.chunk_done   = cdone;
      r.stream_done  = (ph == P_HALT) && (err == STATUS_OK) && end_flag;
      r.status       = err;
      if (cdone && !end_flag) begin
         len_acc = 0;
         type_acc = 0;
         crc_acc = 0;
      end
      return r;
   endfunction

   task automatic add_byte(input logic [7:0] v);
      stim_row_type row;
      row = '0;
      row.b = v;
      byte_plan = {byte_plan, row};
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int k = 3; k >= 0; k--) add_byte(w[8*k +: 8]);
   endtask

   // uniform random wait, with occasional runs of back-to-back requests
   function automatic int unsigned pick_wait(inout int unsigned calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 80);
      return $urandom_range(0, 14);
   endfunction

   task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("png_chunk_deframer regression: fail");
      $finish;
   end

   // response side
   initial begin
      int unsigned calm_left;
      int unsigned hold;
      result_type  exp_rsp;
      calm_left = 0;
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         hold = pick_wait(calm_left);
         if (rsp_seen == HOLD_AT) hold = HOLD_CYCLES;
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: data_byte 0x%0h", rsp_chan.data_byte);
            mismatch_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            cmp_field("byte_role", exp_rsp.byte_role, rsp_chan.byte_role);
            cmp_field("data_byte", exp_rsp.data_byte, rsp_chan.data_byte);
            cmp_field("chunk_length", exp_rsp.chunk_length, rsp_chan.chunk_length);
            cmp_field("chunk_type", exp_rsp.chunk_type, rsp_chan.chunk_type);
            cmp_field("chunk_crc", exp_rsp.chunk_crc, rsp_chan.chunk_crc);
            cmp_field("chunk_done", exp_rsp.chunk_done, rsp_chan.chunk_done);
            cmp_field("stream_done", exp_rsp.stream_done, rsp_chan.stream_done);
            cmp_field("status", exp_rsp.status, rsp_chan.status);
         end
      end
   end

   // request side
   initial begin
      int unsigned  calm_left;
      int unsigned  gap;
      int unsigned  len;
      logic [31:0]  ctype;
      stim_row_type row;
      result_type   predicted;

      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.byte_value <= 8'h00;
      calm_left = 0;

      ph = P_SIG;
      pos = 0;
      len_acc = 0;
      type_acc = 0;
      crc_acc = 0;
      end_flag = 1'b0;
      err = STATUS_OK;

      // now and then a run with a corrupted signature, which ignores the rest
      if ($urandom_range(0, 9) == 0) begin
         directed_rows[$urandom_range(0, 7)].b ^= 8'($urandom_range(1, 255));
         foreach (directed_rows[k]) directed_rows[k].known = 1'b0;
      end
      foreach (directed_rows[k]) byte_plan = {byte_plan, directed_rows[k]};

      while (byte_plan.size() < STREAM_BYTES) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 24);
         add_word(len);
         add_word(($urandom_range(0, 5) == 0) ? IEND_TYPE : $urandom);
         repeat (len) add_byte(8'($urandom_range(0, 255)));
         add_word($urandom);
      end
      // zero-length chunk ends the stream, a bad type now and then
      add_word(32'd0);
      ctype = IEND_TYPE;
      if ($urandom_range(0, 3) == 0) begin
         ctype = $urandom;
         if (ctype == IEND_TYPE) ctype = ~IEND_TYPE;
      end
      add_word(ctype);
      add_word($urandom);
      repeat (NOISE_BYTES) add_byte(8'($urandom_range(0, 255)));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (byte_plan[i]) begin
         row = byte_plan[i];
         gap = pick_wait(calm_left);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_chan.valid <= 1'b1;
         req_chan.byte_value <= row.b;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         predicted = deframe_byte(row.b);
         pending_rsp = {pending_rsp, (row.known ? row.want : predicted)};
      end
      req_chan.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("png_chunk_deframer regression: pass");
      end else begin
         $display("png_chunk_deframer regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
